@@ hdl/cwl_pkg.sv @@
// ----------------------------------------------------------------------------
// cwl_pkg
// Shared types and constants for the cyclic waypoint interpolation generator.
// ----------------------------------------------------------------------------
package cwl_pkg;

  localparam int JOINTS_DEF        = 12;
  localparam int MAX_WAYPOINTS_DEF = 8;

  localparam int POS_BITS   = 16;  // signed Q4.12 radians
  localparam int DUR_BITS   = 16;  // duration and tick counter width
  localparam int RATE_BITS  = 16;  // Q0.16 fraction bits
  localparam int CNT_BITS   = 4;   // configuration register width
  localparam int ACT_BITS   = 3;
  localparam int STEP_BITS  = 3;
  localparam int JOINT_BITS = 4;

  localparam logic [RATE_BITS:0] RATE_ONE = {1'b1, {RATE_BITS{1'b0}}};
  localparam logic [CNT_BITS-1:0] WAYPOINT_COUNT_RST = CNT_BITS'(4);

  typedef enum logic [ACT_BITS-1:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_WP_POS = 3'd2,
    ACT_WP_DUR = 3'd3,
    ACT_BEGIN  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_OUT,
    S_WRAP
  } state_t;

  typedef struct packed {
    logic start;      // latch a tick and set up the divider
    logic div_step;   // one quotient bit
    logic mul;        // multiply for the current joint
    logic out_load;   // load the output register
    logic wrap_step;  // one compare/subtract of the waypoint wrap
  } cmd_t;

  typedef struct packed {
    logic running;
    logic div_done;
    logic slot_free;
    logic last_joint;
    logic advance;
    logic wrap_done;
  } status_t;

endpackage

@@ hdl/cwl_ram.sv @@
// ----------------------------------------------------------------------------
// cwl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cwl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/cwl_ctrl.sv @@
// ----------------------------------------------------------------------------
// cwl_ctrl
// Sequencer: divide, then multiply and emit one joint at a time, then wrap on a waypoint advance.
// ----------------------------------------------------------------------------
module cwl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       action,
  output logic             in_ready,
  input  cwl_pkg::status_t status,
  output cwl_pkg::cmd_t    cmd
);

  import cwl_pkg::*;

  state_t state;
  state_t state_next;
  logic   tick_go;

  assign tick_go = in_valid && (action == ACT_TICK) && status.running;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_go) state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.slot_free) begin
          if (!status.last_joint) state_next = S_MUL;
          else if (status.advance) state_next = S_WRAP;
          else state_next = S_IDLE;
        end
      end
      S_WRAP: begin
        if (status.wrap_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = tick_go;
      end
      S_DIV:  cmd.div_step  = 1'b1;
      S_MUL:  cmd.mul       = 1'b1;
      S_OUT:  cmd.out_load  = status.slot_free;
      S_WRAP: cmd.wrap_step = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ hdl/cwl_datapath.sv @@
// ----------------------------------------------------------------------------
// cwl_datapath
// Storage, Q0.16 rate divider, shared multiply-add and output register.
// ----------------------------------------------------------------------------
module cwl_datapath #(
  parameter int JOINTS        = cwl_pkg::JOINTS_DEF,
  parameter int MAX_WAYPOINTS = cwl_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cwl_pkg::CNT_BITS-1:0]      cfg_wr_data,
  input  logic                              in_accept,
  input  logic [cwl_pkg::ACT_BITS-1:0]      action,
  input  logic [cwl_pkg::STEP_BITS-1:0]     step_index,
  input  logic [cwl_pkg::JOINT_BITS-1:0]    joint_index,
  input  logic signed [cwl_pkg::POS_BITS-1:0] position_value,
  input  logic [cwl_pkg::DUR_BITS-1:0]      duration_ticks,
  input  cwl_pkg::cmd_t                     cmd,
  output cwl_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cwl_pkg::JOINT_BITS-1:0]    joint_number,
  output logic signed [cwl_pkg::POS_BITS-1:0] setpoint,
  output logic [cwl_pkg::STEP_BITS-1:0]     active_step,
  output logic                              last_joint
);

  import cwl_pkg::*;

  localparam int CW_BITS   = $clog2(MAX_WAYPOINTS);
  localparam int JB        = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int ADDR_BITS = $clog2(MAX_WAYPOINTS * JOINTS);
  localparam int DCNT_BITS = $clog2(RATE_BITS);

  // configuration and run state
  logic [CNT_BITS-1:0]  waypoint_count;
  logic                 running;
  logic [CW_BITS-1:0]   cw;
  logic [CW_BITS:0]     wrap;
  logic [CW_BITS:0]     used;
  logic [DUR_BITS-1:0]  tick_count;
  logic [POS_BITS-1:0]  start_pos [JOINTS];
  logic [DUR_BITS-1:0]  dur_mem [MAX_WAYPOINTS];

  // divider
  logic [DUR_BITS-1:0]  dur_eff;
  logic [DUR_BITS-1:0]  dur_sel;
  logic [DUR_BITS:0]    rem;
  logic [DUR_BITS:0]    rem_shift;
  logic [RATE_BITS-1:0] quo;
  logic [DCNT_BITS-1:0] div_cnt;
  logic                 ge;
  logic [RATE_BITS:0]   rate;

  // multiply-add
  logic [ADDR_BITS-1:0]        wp_addr;
  logic [ADDR_BITS-1:0]        wr_addr;
  logic [POS_BITS-1:0]         wp_data;
  logic [JB-1:0]               j;
  logic signed [POS_BITS:0]    diff;
  logic signed [RATE_BITS+1:0] rate_s;
  logic signed [POS_BITS+RATE_BITS+2:0] prod;
  logic [POS_BITS-1:0]         s_hold;

  // load decode
  logic [CW_BITS+STEP_BITS-1:0] step_w;
  logic [CW_BITS-1:0]           step_idx;
  logic                         step_ok;
  logic                         joint_ok;
  logic                         wp_we;
  logic [CW_BITS+2:0]           cw_ext;

  assign step_w   = (CW_BITS+STEP_BITS)'(step_index);
  assign step_idx = step_w[CW_BITS-1:0];
  assign step_ok  = step_w < MAX_WAYPOINTS;
  assign joint_ok = joint_index < JOINTS;
  assign wp_we    = in_accept && (action == ACT_WP_POS) && step_ok && joint_ok;
  assign wr_addr  = ADDR_BITS'(step_idx) * ADDR_BITS'(JOINTS) + ADDR_BITS'(joint_index);

  always_comb begin
    if (waypoint_count == '0) begin
      used = (CW_BITS+1)'(1);
    end else if (waypoint_count > MAX_WAYPOINTS) begin
      used = (CW_BITS+1)'(MAX_WAYPOINTS);
    end else begin
      used = (CW_BITS+1)'(waypoint_count);
    end
  end

  // zero duration counts as one tick
  assign dur_sel   = (dur_mem[cw] == '0) ? DUR_BITS'(1) : dur_mem[cw];
  assign rem_shift = {rem[DUR_BITS-1:0], 1'b0};
  assign rate      = ge ? RATE_ONE : {1'b0, quo};
  assign rate_s    = $signed({1'b0, rate});
  assign diff      = $signed({wp_data[POS_BITS-1], wp_data})
                   - $signed({start_pos[j][POS_BITS-1], start_pos[j]});

  cwl_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (MAX_WAYPOINTS * JOINTS)
  ) u_wp_ram (
    .clk     (clk),
    .we      (wp_we),
    .wr_addr (wr_addr),
    .wr_data (position_value),
    .rd_addr (wp_addr),
    .rd_data (wp_data)
  );

  // configuration, loads and run sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= WAYPOINT_COUNT_RST;
      running        <= 1'b0;
      cw             <= '0;
      tick_count     <= '0;
      j              <= '0;
      for (int i = 0; i < JOINTS; i++) begin
        start_pos[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        waypoint_count <= cfg_wr_data;
      end
      if (in_accept && (action == ACT_BEGIN)) begin
        running <= 1'b1;
      end
      if (in_accept && (action == ACT_START) && !running && joint_ok) begin
        start_pos[JB'(joint_index)] <= position_value;
      end
      // on completion the old target becomes the next start
      if (cmd.mul && ge) begin
        start_pos[j] <= wp_data;
      end
      if (cmd.out_load) begin
        if (j == JB'(JOINTS - 1)) begin
          j          <= '0;
          tick_count <= ge ? '0 : tick_count + DUR_BITS'(1);
          wrap       <= {1'b0, cw} + (CW_BITS+1)'(1);
        end else begin
          j <= j + JB'(1);
        end
      end
      if (cmd.wrap_step) begin
        if (wrap < used) begin
          cw <= wrap[CW_BITS-1:0];
        end else begin
          wrap <= wrap - used;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (action == ACT_WP_DUR) && step_ok) begin
      dur_mem[step_idx] <= duration_ticks;
    end
  end

  // restoring divider: rate = tick_count * 2^16 / duration while tick_count < duration
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dur_eff <= dur_sel;
      ge      <= tick_count >= dur_sel;
      rem     <= {1'b0, tick_count};
      quo     <= '0;
      div_cnt <= '0;
      wp_addr <= ADDR_BITS'(cw) * ADDR_BITS'(JOINTS);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DCNT_BITS'(1);
      if (rem_shift >= {1'b0, dur_eff}) begin
        rem <= rem_shift - {1'b0, dur_eff};
        quo <= {quo[RATE_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[RATE_BITS-2:0], 1'b0};
      end
    end else if (cmd.mul) begin
      // advance now so the next joint's target is ready at its multiply
      wp_addr <= wp_addr + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod   <= rate_s * diff;
      s_hold <= start_pos[j];
    end
  end

  // output register; floor of prod / 2^16 is the arithmetic upper part
  assign cw_ext = (CW_BITS+3)'(cw);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      joint_number <= JOINT_BITS'(j);
      setpoint     <= prod[POS_BITS+RATE_BITS-1:RATE_BITS] + s_hold;
      active_step  <= cw_ext[STEP_BITS-1:0];
      last_joint   <= (j == JB'(JOINTS - 1));
    end
  end

  assign status.running    = running;
  assign status.div_done   = (div_cnt == DCNT_BITS'(RATE_BITS - 1));
  assign status.slot_free  = !out_valid || out_ready;
  assign status.last_joint = (j == JB'(JOINTS - 1));
  assign status.advance    = ge;
  assign status.wrap_done  = wrap < used;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && !ge) |-> (rem < {1'b0, dur_eff}))
    else $error("divider remainder reached the divisor");

  a_joint_in_range: assert property (@(posedge clk) disable iff (rst)
    j < JOINTS)
    else $error("joint counter out of range");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

  a_count_clears_on_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && status.last_joint && ge) |=> (tick_count == '0))
    else $error("tick count not cleared on waypoint advance");

endmodule

@@ hdl/cyclic_waypoint_lerp_generator_unit.sv @@
// ----------------------------------------------------------------------------
// cyclic_waypoint_lerp_generator_unit
// Linear joint setpoint generator over a cyclic table of waypoints.
// ----------------------------------------------------------------------------
// Load, begin and idle ticks give no result.
// A running tick is accepted and runs the 16-step bit-serial rate divider, then a multiply
// on the shared multiply-add and an output load for each joint in turn, then the
// compare/subtract wrap steps on a waypoint advance; output stalls hold the sequence.
// Reset: not running, waypoint 0, tick count 0, start positions 0, count 4.
module cyclic_waypoint_lerp_generator_unit #(
  parameter int JOINTS        = cwl_pkg::JOINTS_DEF,
  parameter int MAX_WAYPOINTS = cwl_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [cwl_pkg::CNT_BITS-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cwl_pkg::ACT_BITS-1:0]        action,
  input  logic [cwl_pkg::STEP_BITS-1:0]       step_index,
  input  logic [cwl_pkg::JOINT_BITS-1:0]      joint_index,
  input  logic signed [cwl_pkg::POS_BITS-1:0] position_value,
  input  logic [cwl_pkg::DUR_BITS-1:0]        duration_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cwl_pkg::JOINT_BITS-1:0]      joint_number,
  output logic signed [cwl_pkg::POS_BITS-1:0] setpoint,
  output logic [cwl_pkg::STEP_BITS-1:0]       active_step,
  output logic                                last_joint
);

  import cwl_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_accept;

  assign in_accept = in_valid && in_ready;

  cwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cwl_datapath #(
    .JOINTS        (JOINTS),
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_accept      (in_accept),
    .action         (action),
    .step_index     (step_index),
    .joint_index    (joint_index),
    .position_value (position_value),
    .duration_ticks (duration_ticks),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .joint_number   (joint_number),
    .setpoint       (setpoint),
    .active_step    (active_step),
    .last_joint     (last_joint)
  );

endmodule

@@ test/cwl_setpoint_checker.sv @@
// ----------------------------------------------------------------------------
// cwl_setpoint_checker
// Watches the configuration, input and result channels of the waypoint
// interpolation generator. It predicts the setpoints of every running tick and
// compares each accepted result with the oldest pending setpoint, field by field.
// ----------------------------------------------------------------------------
module cwl_setpoint_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [cwl_pkg::CNT_BITS-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [cwl_pkg::ACT_BITS-1:0]        action,
  input  logic [cwl_pkg::STEP_BITS-1:0]       step_index,
  input  logic [cwl_pkg::JOINT_BITS-1:0]      joint_index,
  input  logic signed [cwl_pkg::POS_BITS-1:0] position_value,
  input  logic [cwl_pkg::DUR_BITS-1:0]        duration_ticks,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [cwl_pkg::JOINT_BITS-1:0]      joint_number,
  input  logic signed [cwl_pkg::POS_BITS-1:0] setpoint,
  input  logic [cwl_pkg::STEP_BITS-1:0]       active_step,
  input  logic                                last_joint,
  output int                                  failures,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cwl_pkg::*;

  localparam longint FULL_RATE = longint'(RATE_ONE);

  typedef struct packed {
    logic [JOINT_BITS-1:0]      joint;
    logic signed [POS_BITS-1:0] angle;
    logic [STEP_BITS-1:0]       step;
    logic                       last;
  } setpoint_t;

  setpoint_t due_setpoints[$];

  logic [CNT_BITS-1:0]        waypoint_count_q;
  logic                       running_q;
  int unsigned                target_wp;
  logic [DUR_BITS-1:0]        tick_count_q;
  logic signed [POS_BITS-1:0] start_pos [JOINTS_DEF];
  logic signed [POS_BITS-1:0] wp_pos [MAX_WAYPOINTS_DEF][JOINTS_DEF];
  logic [DUR_BITS-1:0]        wp_dur [MAX_WAYPOINTS_DEF];

  // A count of 0 behaves as 1, anything above the table size as the table size.
  function automatic int unsigned waypoints_in_use();
    if (waypoint_count_q == 0) return 1;
    if (waypoint_count_q > MAX_WAYPOINTS_DEF) return MAX_WAYPOINTS_DEF;
    return waypoint_count_q;
  endfunction

  task automatic interpolate_tick();
    int unsigned wp;
    longint      dur;
    longint      frac;
    longint      delta;
    longint      offset;
    setpoint_t   sp;
    wp   = target_wp % MAX_WAYPOINTS_DEF;
    dur  = (wp_dur[wp] == 0) ? 1 : longint'(wp_dur[wp]);
    frac = (longint'(tick_count_q) >= dur) ? FULL_RATE
                                            : longint'(tick_count_q) * FULL_RATE / dur;
    for (int j = 0; j < JOINTS_DEF; j++) begin
      delta  = longint'(wp_pos[wp][j]) - longint'(start_pos[j]);
      // arithmetic shift gives the floor of the scaled step, also below zero
      offset = (frac * delta) >>> RATE_BITS;
      sp.joint = JOINT_BITS'(j);
      sp.angle = POS_BITS'(longint'(start_pos[j]) + offset);
      sp.step  = STEP_BITS'(wp);
      sp.last  = (j == JOINTS_DEF - 1);
      due_setpoints = {due_setpoints, sp};
    end
    tick_count_q = tick_count_q + 1'b1;
    if (frac >= FULL_RATE) begin
      foreach (start_pos[j]) start_pos[j] = wp_pos[wp][j];
      target_wp    = (wp + 1) % waypoints_in_use();
      tick_count_q = '0;
    end
  endtask

  task automatic check_result();
    setpoint_t sp;
    if (due_setpoints.size() == 0) begin
      $error("result for joint %0d with no setpoint pending", joint_number);
      failures++;
    end else begin
      sp = due_setpoints.pop_front();
      if (joint_number !== sp.joint) begin
        $error("joint_number mismatch: expected %0d, got %0d", sp.joint, joint_number);
        failures++;
      end
      if (setpoint !== sp.angle) begin
        $error("setpoint mismatch: expected %0d, got %0d", sp.angle, setpoint);
        failures++;
      end
      if (active_step !== sp.step) begin
        $error("active_step mismatch: expected %0d, got %0d", sp.step, active_step);
        failures++;
      end
      if (last_joint !== sp.last) begin
        $error("last_joint mismatch: expected %0d, got %0d", sp.last, last_joint);
        failures++;
      end
    end
  endtask

  task automatic accept_item();
    case (action)
      ACT_START: begin
        if (!running_q && joint_index < JOINTS_DEF) start_pos[joint_index] = position_value;
      end
      ACT_WP_POS: begin
        if (joint_index < JOINTS_DEF) wp_pos[step_index][joint_index] = position_value;
      end
      ACT_WP_DUR: wp_dur[step_index] = duration_ticks;
      ACT_BEGIN:  running_q = 1'b1;
      ACT_TICK: begin
        if (running_q) interpolate_tick();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      waypoint_count_q = WAYPOINT_COUNT_RST;
      running_q        = 1'b0;
      target_wp        = 0;
      tick_count_q     = '0;
      foreach (start_pos[j]) start_pos[j] = '0;
      due_setpoints.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_wr_en) waypoint_count_q = cfg_wr_data;
      if (in_valid && in_ready) accept_item();
    end
    pending <= due_setpoints.size();
  end

endmodule

@@ test/cyclic_waypoint_lerp_generator_unit_test.sv @@
// ----------------------------------------------------------------------------
// cyclic_waypoint_lerp_generator_unit_test
// Drives loads, begin and ticks into the waypoint interpolation generator with
// random gaps on both channels, changes the waypoint count between phases and
// leaves all checking to the setpoint checker instantiated beside the block.
// ----------------------------------------------------------------------------
module cyclic_waypoint_lerp_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cwl_pkg::*;

  localparam logic [ACT_BITS-1:0]        ACT_RESERVED_LO = 3'd5;
  localparam logic [ACT_BITS-1:0]        ACT_RESERVED_HI = 3'd7;
  localparam logic signed [POS_BITS-1:0] POS_MAX         = 16'sh7FFF;
  localparam logic signed [POS_BITS-1:0] POS_MIN         = 16'sh8000;
  localparam logic [DUR_BITS-1:0]        DUR_MAX         = 16'hFFFF;
  localparam int                         SETTLE_CYCLES   = 64;
  localparam int                         LONG_HOLD       = 400;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [CNT_BITS-1:0]        cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [ACT_BITS-1:0]        action = '0;
  logic [STEP_BITS-1:0]       step_index = '0;
  logic [JOINT_BITS-1:0]      joint_index = '0;
  logic signed [POS_BITS-1:0] position_value = '0;
  logic [DUR_BITS-1:0]        duration_ticks = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [JOINT_BITS-1:0]      joint_number;
  logic signed [POS_BITS-1:0] setpoint;
  logic [STEP_BITS-1:0]       active_step;
  logic                       last_joint;
  int                         failures;
  int                         pending;

  bit sender_quiet;
  bit hold_request;

  cyclic_waypoint_lerp_generator_unit DUT (.*);

  cwl_setpoint_checker checker_i (.*);

  always #5 clk = ~clk;

  initial begin : watchdog
    #5ms;
    $display("cyclic_waypoint_lerp_generator_unit verification failed");
    $finish;
  end

  // result side: random stall per result, calm stretches, one long hold on request
  initial begin : result_sink
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 15);
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic send_item(input logic [ACT_BITS-1:0] act, input logic [STEP_BITS-1:0] step,
                           input logic [JOINT_BITS-1:0] joint,
                           input logic signed [POS_BITS-1:0] pos,
                           input logic [DUR_BITS-1:0] dur);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    step_index     <= step;
    joint_index    <= joint;
    position_value <= pos;
    duration_ticks <= dur;
    do @(posedge clk); while (!in_ready);
  endtask

  // unused fields carry random noise
  task automatic send_bare(input logic [ACT_BITS-1:0] act);
    send_item(act, STEP_BITS'($urandom), JOINT_BITS'($urandom), POS_BITS'($urandom),
              DUR_BITS'($urandom));
  endtask

  task automatic tick();
    send_bare(ACT_TICK);
  endtask

  task automatic begin_run();
    send_bare(ACT_BEGIN);
  endtask

  task automatic load_start(input int joint, input logic signed [POS_BITS-1:0] pos);
    send_item(ACT_START, STEP_BITS'($urandom), JOINT_BITS'(joint), pos, DUR_BITS'($urandom));
  endtask

  task automatic load_pos(input int step, input int joint,
                          input logic signed [POS_BITS-1:0] pos);
    send_item(ACT_WP_POS, STEP_BITS'(step), JOINT_BITS'(joint), pos, DUR_BITS'($urandom));
  endtask

  task automatic load_dur(input int step, input int dur);
    send_item(ACT_WP_DUR, STEP_BITS'(step), JOINT_BITS'($urandom), POS_BITS'($urandom),
              DUR_BITS'(dur));
  endtask

  function automatic logic signed [POS_BITS-1:0] any_position();
    case ($urandom_range(0, 7))
      0:       return POS_MIN;
      1:       return POS_MAX;
      default: return POS_BITS'($urandom);
    endcase
  endfunction

  task automatic fill_waypoint(input int step, input int dur);
    for (int j = 0; j < JOINTS_DEF; j++) load_pos(step, j, any_position());
    load_dur(step, dur);
  endtask

  // drop valid, wait for every pending setpoint, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input int count);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_BITS'(count);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) tick();
    else if (pick < 70) load_dur($urandom_range(0, 7), $urandom_range(0, 4));
    else if (pick < 73) load_dur($urandom_range(0, 7), $urandom_range(0, DUR_MAX));
    else if (pick < 85) load_pos($urandom_range(0, 7), $urandom_range(0, 15), any_position());
    else if (pick < 90) load_start($urandom_range(0, 15), any_position());
    else if (pick < 94) begin_run();
    else send_bare(ACT_BITS'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI)));
  endtask

  task automatic random_phase(input int items);
    sender_quiet = ($urandom_range(0, 3) == 0);
    repeat (items) random_item();
  endtask

  initial begin : stimulus
    sender_quiet = 1'b0;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_count(4);

    // idle block: no results for ticks, reserved codes or bad joint indexes
    tick();
    for (int code = ACT_RESERVED_LO; code <= ACT_RESERVED_HI; code++)
      send_bare(ACT_BITS'(code));
    load_start(0, POS_MAX);
    load_start(11, POS_MIN);
    load_start(12, POS_MIN);
    load_start(15, POS_MAX);
    load_pos(0, 13, POS_MAX);

    // waypoint 0 has zero duration, waypoint 1 the longest one
    fill_waypoint(0, 0);
    fill_waypoint(1, DUR_MAX);
    fill_waypoint(2, 3);
    fill_waypoint(3, 1);
    load_pos(0, 0, POS_MIN);
    load_pos(0, 11, POS_MAX);

    begin_run();
    begin_run();
    load_start(3, POS_MAX);
    repeat (5) tick();
    // shorten the long waypoint below the tick count: rate clamps and advances
    load_dur(1, 2);
    repeat (9) tick();

    random_phase(6);
    for (int k = 4; k < MAX_WAYPOINTS_DEF; k++) fill_waypoint(k, $urandom_range(0, 4));

    // full table; the sink stalls while ticks keep coming
    set_count(8);
    sender_quiet = 1'b1;
    hold_request = 1'b1;
    repeat (8) tick();
    random_phase(4);

    // lowering the count may leave the current waypoint beyond it
    set_count(2);
    random_phase(3);
    set_count(1);
    random_phase(3);
    set_count(0);
    random_phase(3);
    set_count(15);
    random_phase(3);
    repeat (3) begin
      set_count($urandom_range(1, 8));
      random_phase(2);
    end

    settle();
    if (failures == 0 && pending == 0) begin
      $display("cyclic_waypoint_lerp_generator_unit verification clean");
    end else begin
      $display("cyclic_waypoint_lerp_generator_unit verification failed");
    end
    $finish;
  end

endmodule
